// ===== design/rppe_pkg.sv =====
// Package for the rotating P+Q parity engine: sizes, the queue word type and
// the GF(2^8) and row-rotation helper functions. No dependencies.
package rppe_pkg;

	localparam int MAX_DATA_DISKS = 8;
	localparam int PARITY_DISKS   = 2;
	localparam int FIFO_DEPTH     = 2;
	localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] REG_DATA_DISKS  = 2'd0;
	localparam logic [1:0] REG_Q_COEFS     = 2'd1;
	localparam logic [1:0] REG_ERASED_DISK = 2'd2;

	localparam logic CMD_ENCODE  = 1'b0;
	localparam logic CMD_REBUILD = 1'b1;

	localparam logic [8:0] GF_POLY = 9'h11D;

	// One classified word as it travels from the front to the back.
	typedef struct packed {
		logic       cmd;
		logic       last;
		logic       add_xor;
		logic       add_ws;
		logic       q_erased;
		logic [7:0] coef;
		logic [7:0] data;
		logic [3:0] p_disk;
		logic [3:0] q_disk;
	} rppe_item_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] x;
		logic [7:0] acc;
		x   = {1'b0, a};
		acc = 8'h00;
		for (int n = 0; n < 8; n++) begin
			if (b[n]) begin
				acc = acc ^ x[7:0];
			end
			x = {x[7:0], 1'b0};
			if (x[8]) begin
				x = x ^ GF_POLY;
			end
		end
		return acc;
	endfunction

	// Row modulo k, with row below 8 and k at least 2: three subtractions suffice.
	function automatic logic [2:0] row_mod(input logic [2:0] row, input logic [3:0] k);
		logic [3:0] r;
		r = {1'b0, row};
		for (int n = 0; n < 3; n++) begin
			if (r >= k) begin
				r = r - k;
			end
		end
		return r[2:0];
	endfunction

endpackage

// ===== design/rppe_front.sv =====
// Front end of the parity engine: holds the configuration registers and
// classifies each accepted word into a queue word. Depends on rppe_pkg.
module rppe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_wdata,
	input  logic              cmd,
	input  logic [2:0]        row,
	input  logic [3:0]        disk,
	input  logic [7:0]        byte_in,
	input  logic              last,
	output rppe_pkg::rppe_item_t item
);
	import rppe_pkg::*;

	logic [3:0]  data_disks_q;
	logic [63:0] q_coefs_q;
	logic [3:0]  erased_disk_q;

	logic [3:0] k;
	logic [2:0] r;
	logic [3:0] pd;
	logic [3:0] qd;
	logic [3:0] idx;
	logic       enc_ok;
	logic       reb_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_disks_q  <= 4'd4;
			q_coefs_q     <= '0;
			erased_disk_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DATA_DISKS:  data_disks_q  <= cfg_wdata[3:0];
				REG_Q_COEFS:     q_coefs_q     <= cfg_wdata;
				REG_ERASED_DISK: erased_disk_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (data_disks_q < 4'd2) begin
			k = 4'd2;
		end else if (data_disks_q > 4'(MAX_DATA_DISKS)) begin
			k = 4'(MAX_DATA_DISKS);
		end else begin
			k = data_disks_q;
		end
		r  = row_mod(row, k);
		pd = k - {1'b0, r};
		qd = pd + 4'd1;

		enc_ok = (disk < k);
		reb_ok = (disk < k + 4'(PARITY_DISKS)) && (disk != erased_disk_q) && (disk != qd);

		// Data disks past the P disk sit two places further along.
		if (cmd == CMD_ENCODE || disk < pd) begin
			idx = disk;
		end else begin
			idx = disk - 4'(PARITY_DISKS);
		end

		item.cmd      = cmd;
		item.last     = last;
		item.data     = byte_in;
		item.p_disk   = pd;
		item.q_disk   = qd;
		item.q_erased = (erased_disk_q == qd);
		item.coef     = q_coefs_q[idx[2:0] * 8 +: 8];
		if (cmd == CMD_ENCODE) begin
			item.add_xor = enc_ok;
			item.add_ws  = enc_ok;
		end else begin
			item.add_xor = reb_ok;
			item.add_ws  = reb_ok && (disk != pd);
		end
	end

endmodule

// ===== design/rppe_fifo.sv =====
// Short register queue that decouples the classifying front from the
// accumulating back. Depends on rppe_pkg.
module rppe_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rppe_pkg::rppe_item_t push_item,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output rppe_pkg::rppe_item_t head
);
	import rppe_pkg::*;

	rppe_item_t            mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	function automatic logic [FIFO_PTR_W-1:0] next_ptr(input logic [FIFO_PTR_W-1:0] p);
		if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
			return '0;
		end
		return p + FIFO_PTR_W'(1);
	endfunction

	assign full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/rppe_back.sv =====
// Back end of the parity engine: multiplies each queued byte by its Q
// coefficient, keeps the running sums and drives the result register.
// Depends on rppe_pkg.
module rppe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  rppe_pkg::rppe_item_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        p_value,
	output logic [7:0]        q_value,
	output logic [3:0]        p_disk,
	output logic [3:0]        q_disk,
	output logic [7:0]        rebuilt
);
	import rppe_pkg::*;

	logic [7:0] data_xor_q;
	logic [7:0] weighted_sum_q;
	logic       out_valid_q;
	logic [7:0] p_value_q;
	logic [7:0] q_value_q;
	logic [3:0] p_disk_q;
	logic [3:0] q_disk_q;
	logic [7:0] rebuilt_q;

	logic [7:0] xor_next;
	logic [7:0] ws_next;
	logic       out_free;
	logic       emit;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = head_valid && (!head.last || out_free);
	assign emit     = pop && head.last;

	always_comb begin
		xor_next = data_xor_q ^ (head.add_xor ? head.data : 8'h00);
		ws_next  = weighted_sum_q ^ (head.add_ws ? gf_mul(head.data, head.coef) : 8'h00);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_xor_q     <= '0;
			weighted_sum_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				data_xor_q     <= head.last ? 8'h00 : xor_next;
				weighted_sum_q <= head.last ? 8'h00 : ws_next;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			p_disk_q <= head.p_disk;
			q_disk_q <= head.q_disk;
			if (head.cmd == CMD_ENCODE) begin
				p_value_q <= xor_next;
				q_value_q <= ws_next;
				rebuilt_q <= 8'h00;
			end else begin
				p_value_q <= 8'h00;
				q_value_q <= 8'h00;
				rebuilt_q <= head.q_erased ? ws_next : xor_next;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign p_value   = p_value_q;
	assign q_value   = q_value_q;
	assign p_disk    = p_disk_q;
	assign q_disk    = q_disk_q;
	assign rebuilt   = rebuilt_q;

endmodule

// ===== design/rotating_pq_parity_engine.sv =====
// Rotating P+Q parity engine: one disk byte word in per cycle while in_stall is low, P/Q or a rebuilt byte out.
// The back end loads a position's result into the output register when it pops the
// position's last word from the queue, which it does only while the output is free.
// Throughput: one word per cycle unless the queue fills; the GF multiply and accumulate is combinational.
// Reset (arst_n, asynchronous, active low) empties the queue and the output register,
// clears the running sums and sets data_disks to 4 and the other registers to zero.
module rotating_pq_parity_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [2:0]  row,
	input  logic [3:0]  disk,
	input  logic [7:0]  byte_in,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  p_value,
	output logic [7:0]  q_value,
	output logic [3:0]  p_disk,
	output logic [3:0]  q_disk,
	output logic [7:0]  rebuilt
);
	import rppe_pkg::*;

	rppe_item_t front_item;
	rppe_item_t head_item;
	logic       fifo_full;
	logic       fifo_not_empty;
	logic       push;
	logic       pop;

	// The front works out the rotated parity placement for the word's row and
	// decides which sums the word feeds; nothing here waits on the back end.
	rppe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.row       (row),
		.disk      (disk),
		.byte_in   (byte_in),
		.last      (last),
		.item      (front_item)
	);

	// A word is taken whenever the queue has room, so the input side keeps
	// running while a finished result still waits at the output.
	assign in_stall = fifo_full;
	assign push     = in_valid && !fifo_full;

	rppe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.full      (fifo_full),
		.not_empty (fifo_not_empty),
		.head      (head_item)
	);

	// The back consumes ordinary words freely and holds a closing word only
	// while the output register is occupied and stalled.
	rppe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (fifo_not_empty),
		.head       (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.p_value    (p_value),
		.q_value    (q_value),
		.p_disk     (p_disk),
		.q_disk     (q_disk),
		.rebuilt    (rebuilt)
	);

endmodule

// ===== design/rppe_chk.sv =====
// Port-level checker for the rotating P+Q parity engine and its bind.
// Depends only on the ports of rotating_pq_parity_engine.
module rppe_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  p_value,
	input logic [7:0]  q_value,
	input logic [3:0]  p_disk,
	input logic [3:0]  q_disk,
	input logic [7:0]  rebuilt
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(p_value) && $stable(q_value)
			&& $stable(rebuilt) && $stable(p_disk) && $stable(q_disk))
		else $error("stalled result word changed");

	a_mode_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rebuilt == 8'h00) || (p_value == 8'h00 && q_value == 8'h00))
		else $error("encode and rebuild results mixed in one word");

	a_q_follows_p: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> q_disk == p_disk + 4'd1)
		else $error("Q disk does not follow P disk");

	a_p_disk_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> p_disk >= 4'd1 && p_disk <= 4'd8)
		else $error("P disk outside the rotation range");

endmodule

bind rotating_pq_parity_engine rppe_chk u_rppe_chk (.*);
